/* rtl/lavm_pkg.sv */
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AXIS_W    = FRAC_BITS + 2;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int ACC_W     = 64;
  localparam int MAN_W     = 30;
  localparam int SUM_W     = 2 * MAN_W + 2;
  localparam int ROOT_W    = MAN_W + 1;
  localparam int NUM_W     = MAN_W + FRAC_BITS + 1;
  localparam int PROD_W    = 32 + AXIS_W;
  localparam int CNT_W     = 5;

  localparam logic [1:0] ROW_SIDE = 2'd0;
  localparam logic [1:0] ROW_UP   = 2'd1;
  localparam logic [1:0] ROW_FWD  = 2'd2;
  localparam logic [1:0] ROW_LAST = 2'd3;

  typedef logic signed [31:0]       coord_t;
  typedef logic signed [32:0]       diff_t;
  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam acc_t HALF_LSB = acc_t'(64'sd1 <<< (FRAC_BITS - 1));
  localparam acc_t SAT_HI   = 64'sd2147483647;
  localparam acc_t SAT_LO   = -64'sd2147483648;
  localparam logic [31:0] ONE_FIX = 32'(64'd1 << FRAC_BITS);

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] upward_x;
    logic signed [31:0] upward_y;
    logic signed [31:0] upward_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
    logic               degenerate;
  } out_word_t;

  typedef struct packed {
    coord_t [2:0] eye;
    coord_t [2:0] up;
    diff_t  [2:0] dir;
  } job_t;

  typedef struct packed {
    logic done;
    logic nz;
  } norm_stat_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SOS, N_SQRT, N_PREP, N_DIV
  } norm_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NORM_F, B_CROSS_S, B_NORM_S, B_CROSS_U, B_NORM_U, B_DOT, B_EMIT
  } back_state_t;

  function automatic coord_t pick_coord(input logic [1:0] sel, input coord_t v0,
                                        input coord_t v1, input coord_t v2);
    coord_t r;
    case (sel)
      2'd0: r = v0;
      2'd1: r = v1;
      2'd2: r = v2;
      default: r = v2;
    endcase
    return r;
  endfunction

  function automatic axis_t pick_axis(input logic [1:0] sel, input axis_t v0,
                                      input axis_t v1, input axis_t v2);
    axis_t r;
    case (sel)
      2'd0: r = v0;
      2'd1: r = v1;
      2'd2: r = v2;
      default: r = v2;
    endcase
    return r;
  endfunction

endpackage

/* rtl/lavm_fifo.sv */
module lavm_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lavm_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output lavm_pkg::job_t  pop_job
);

  lavm_pkg::job_t ent_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;
  logic       push_ok;
  logic       pop_ok;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_job   = ent_r[rd_r];
  assign push_ok   = push && !full;
  assign pop_ok    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push_ok) wr_r <= !wr_r;
      if (pop_ok) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) ent_r[wr_r] <= push_job;
  end

endmodule

/* rtl/lavm_norm.sv */
module lavm_norm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  lavm_pkg::acc_t [2:0]          vec,
  output lavm_pkg::norm_stat_t          stat,
  output lavm_pkg::axis_t [2:0]         unit
);

  lavm_pkg::norm_state_t state_r, state_nxt;

  logic [lavm_pkg::ACC_W-1:0]    mag_r [3];
  logic                          neg_r [3];
  logic [lavm_pkg::SUM_W-1:0]    sos_r;
  logic [2*lavm_pkg::MAN_W-1:0]  prod_r;
  logic [1:0]                    step_r;
  logic [lavm_pkg::SUM_W-1:0]    n_r;
  logic [lavm_pkg::ROOT_W+1:0]   rem_r;
  logic [lavm_pkg::ROOT_W-1:0]   root_r;
  logic [lavm_pkg::CNT_W-1:0]    cnt_r;
  logic [lavm_pkg::ROOT_W-1:0]   drem_r [3];
  logic [lavm_pkg::QUO_W-1:0]    dlow_r [3];
  logic [lavm_pkg::QUO_W-1:0]    q_r [3];
  logic                          done_r, done_nxt;
  logic                          nz_r;

  logic [lavm_pkg::ACC_W-1:0]    m;
  logic                          m_hi;
  logic                          vzero;
  logic                          last_div;
  logic [lavm_pkg::MAN_W-1:0]    sq_in;
  logic [lavm_pkg::ROOT_W+3:0]   rem2;
  logic [lavm_pkg::ROOT_W+3:0]   trial;

  assign m        = mag_r[0] | mag_r[1] | mag_r[2];
  assign m_hi     = |m[lavm_pkg::ACC_W-1:lavm_pkg::MAN_W];
  assign vzero    = (vec == '0);
  assign last_div = (cnt_r == lavm_pkg::CNT_W'(lavm_pkg::QUO_W - 1));
  assign rem2     = {rem_r, n_r[lavm_pkg::SUM_W-1 -: 2]};
  assign trial    = {2'b00, root_r, 2'b01};

  always_comb begin
    case (step_r)
      2'd0: sq_in = mag_r[0][lavm_pkg::MAN_W-1:0];
      2'd1: sq_in = mag_r[1][lavm_pkg::MAN_W-1:0];
      2'd2: sq_in = mag_r[2][lavm_pkg::MAN_W-1:0];
      default: sq_in = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lavm_pkg::N_IDLE:  if (start && !vzero) state_nxt = lavm_pkg::N_SHIFT;
      lavm_pkg::N_SHIFT: if (!m_hi && m[lavm_pkg::MAN_W-1]) state_nxt = lavm_pkg::N_SOS;
      lavm_pkg::N_SOS:   if (step_r == 2'd3) state_nxt = lavm_pkg::N_SQRT;
      lavm_pkg::N_SQRT: begin
        if (cnt_r == lavm_pkg::CNT_W'(lavm_pkg::ROOT_W - 1)) state_nxt = lavm_pkg::N_PREP;
      end
      lavm_pkg::N_PREP:  state_nxt = lavm_pkg::N_DIV;
      lavm_pkg::N_DIV:   if (last_div) state_nxt = lavm_pkg::N_IDLE;
      default:           state_nxt = lavm_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done_nxt = (state_r == lavm_pkg::N_IDLE && start && vzero) ||
               (state_r == lavm_pkg::N_DIV && last_div);
    stat.done = done_r;
    stat.nz   = nz_r;
    for (int i = 0; i < 3; i++) begin
      if (!nz_r) unit[i] = '0;
      else if (neg_r[i]) unit[i] = -$signed({1'b0, q_r[i]});
      else unit[i] = $signed({1'b0, q_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lavm_pkg::N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      lavm_pkg::N_IDLE: begin
        if (start) begin
          nz_r <= !vzero;
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= vec[i][lavm_pkg::ACC_W-1];
            mag_r[i] <= vec[i][lavm_pkg::ACC_W-1] ? -vec[i] : vec[i];
          end
        end
      end
      lavm_pkg::N_SHIFT: begin
        // bring the largest magnitude into [2^29, 2^30), one bit a cycle
        for (int i = 0; i < 3; i++) begin
          if (m_hi) mag_r[i] <= mag_r[i] >> 1;
          else if (!m[lavm_pkg::MAN_W-1]) mag_r[i] <= mag_r[i] << 1;
        end
        step_r <= 2'd0;
        prod_r <= '0;
        sos_r  <= '0;
      end
      lavm_pkg::N_SOS: begin
        prod_r <= sq_in * sq_in;
        sos_r  <= sos_r + lavm_pkg::SUM_W'(prod_r);
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          n_r    <= sos_r + lavm_pkg::SUM_W'(prod_r);
          rem_r  <= '0;
          root_r <= '0;
          cnt_r  <= '0;
        end
      end
      lavm_pkg::N_SQRT: begin
        if (rem2 >= trial) begin
          rem_r  <= (lavm_pkg::ROOT_W+2)'(rem2 - trial);
          root_r <= {root_r[lavm_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= (lavm_pkg::ROOT_W+2)'(rem2);
          root_r <= {root_r[lavm_pkg::ROOT_W-2:0], 1'b0};
        end
        n_r   <= n_r << 2;
        cnt_r <= cnt_r + 1'b1;
      end
      lavm_pkg::N_PREP: begin
        for (int i = 0; i < 3; i++) begin
          logic [lavm_pkg::NUM_W-1:0] num;
          num = lavm_pkg::NUM_W'({mag_r[i][lavm_pkg::MAN_W-1:0],
                                  {lavm_pkg::FRAC_BITS{1'b0}}}) +
                lavm_pkg::NUM_W'(root_r >> 1);
          drem_r[i] <= lavm_pkg::ROOT_W'(num[lavm_pkg::NUM_W-1:lavm_pkg::QUO_W]);
          dlow_r[i] <= num[lavm_pkg::QUO_W-1:0];
        end
        cnt_r <= '0;
      end
      lavm_pkg::N_DIV: begin
        // three restoring dividers side by side, one quotient bit a cycle
        for (int i = 0; i < 3; i++) begin
          logic [lavm_pkg::ROOT_W:0] r2;
          logic                      ge;
          r2 = {drem_r[i], dlow_r[i][lavm_pkg::QUO_W-1]};
          ge = (r2 >= {1'b0, root_r});
          drem_r[i] <= ge ? lavm_pkg::ROOT_W'(r2 - {1'b0, root_r})
                          : lavm_pkg::ROOT_W'(r2);
          dlow_r[i] <= dlow_r[i] << 1;
          q_r[i]    <= {q_r[i][lavm_pkg::QUO_W-2:0], ge};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/lavm_front.sv */
module lavm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lavm_pkg::in_word_t  in_word,
  output logic                push,
  input  logic                q_full,
  output lavm_pkg::job_t      push_job
);

  logic           vld_r;
  lavm_pkg::job_t job_r;
  logic           load;

  assign in_stall = vld_r && q_full;
  assign load     = in_valid && !in_stall;
  assign push     = vld_r && !q_full;
  assign push_job = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= load || (vld_r && !push);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r.eye[0] <= in_word.eye_x;
      job_r.eye[1] <= in_word.eye_y;
      job_r.eye[2] <= in_word.eye_z;
      job_r.up[0]  <= in_word.upward_x;
      job_r.up[1]  <= in_word.upward_y;
      job_r.up[2]  <= in_word.upward_z;
      job_r.dir[0] <= lavm_pkg::diff_t'($signed(in_word.eye_x)) -
                      lavm_pkg::diff_t'($signed(in_word.aim_x));
      job_r.dir[1] <= lavm_pkg::diff_t'($signed(in_word.eye_y)) -
                      lavm_pkg::diff_t'($signed(in_word.aim_y));
      job_r.dir[2] <= lavm_pkg::diff_t'($signed(in_word.eye_z)) -
                      lavm_pkg::diff_t'($signed(in_word.aim_z));
    end
  end

endmodule

/* rtl/lavm_back.sv */
module lavm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lavm_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lavm_pkg::out_word_t  out_word
);

  lavm_pkg::back_state_t state_r, state_nxt;

  lavm_pkg::job_t      job_r;
  lavm_pkg::axis_t     f_r [3];
  lavm_pkg::axis_t     s_r [3];
  lavm_pkg::axis_t     u_r [3];
  lavm_pkg::acc_t      raw_r [3];
  logic [31:0]         trans_r [3];
  logic                bad_r;
  logic [2:0]          k_r;
  logic                ph_r;
  logic [1:0]          row_r;
  lavm_pkg::prod_t     prod_r;
  lavm_pkg::acc_t      acc_r;
  logic                go_r, go_nxt;
  logic                out_valid_r;
  lavm_pkg::out_word_t out_word_r;

  lavm_pkg::norm_stat_t stat;
  lavm_pkg::axis_t [2:0] unit;
  lavm_pkg::acc_t  [2:0] norm_vec;

  logic [1:0]      sel_a, sel_b;
  logic            sub;
  lavm_pkg::coord_t op_a;
  lavm_pkg::axis_t  op_b;
  lavm_pkg::acc_t   prod_ext, acc_sum, tneg, tsh;
  logic [31:0]      tsat;
  logic             load;
  logic             last_term;
  lavm_pkg::out_word_t row_word;

  lavm_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .vec   (norm_vec),
    .stat  (stat),
    .unit  (unit)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      norm_vec[i] = (state_r == lavm_pkg::B_NORM_F) ?
                    lavm_pkg::acc_t'($signed(job_r.dir[i])) : raw_r[i];
    end
  end

  // term order of a cross product: a1*b2 - a2*b1, a2*b0 - a0*b2, a0*b1 - a1*b0
  always_comb begin
    sel_a = 2'd0;
    sel_b = 2'd0;
    sub   = 1'b0;
    case (k_r)
      3'd0: begin sel_a = 2'd1; sel_b = 2'd2; end
      3'd1: begin sel_a = 2'd2; sel_b = 2'd1; sub = 1'b1; end
      3'd2: begin sel_a = 2'd2; sel_b = 2'd0; end
      3'd3: begin sel_a = 2'd0; sel_b = 2'd2; sub = 1'b1; end
      3'd4: begin sel_a = 2'd0; sel_b = 2'd1; end
      3'd5: begin sel_a = 2'd1; sel_b = 2'd0; sub = 1'b1; end
      default: ;
    endcase
    if (state_r == lavm_pkg::B_DOT) begin
      sel_a = k_r[1:0];
      sel_b = k_r[1:0];
      sub   = 1'b0;
    end
  end

  always_comb begin
    case (state_r)
      lavm_pkg::B_CROSS_S: begin
        op_a = lavm_pkg::pick_coord(sel_a, job_r.up[0], job_r.up[1], job_r.up[2]);
        op_b = lavm_pkg::pick_axis(sel_b, f_r[0], f_r[1], f_r[2]);
      end
      lavm_pkg::B_CROSS_U: begin
        op_a = 32'(lavm_pkg::pick_axis(sel_a, f_r[0], f_r[1], f_r[2]));
        op_b = lavm_pkg::pick_axis(sel_b, s_r[0], s_r[1], s_r[2]);
      end
      default: begin
        op_a = lavm_pkg::pick_coord(sel_a, job_r.eye[0], job_r.eye[1], job_r.eye[2]);
        case (row_r)
          lavm_pkg::ROW_SIDE: op_b = lavm_pkg::pick_axis(sel_b, s_r[0], s_r[1], s_r[2]);
          lavm_pkg::ROW_UP:   op_b = lavm_pkg::pick_axis(sel_b, u_r[0], u_r[1], u_r[2]);
          default:            op_b = lavm_pkg::pick_axis(sel_b, f_r[0], f_r[1], f_r[2]);
        endcase
      end
    endcase
  end

  assign prod_ext = lavm_pkg::acc_t'(prod_r);
  assign acc_sum  = sub ? acc_r - prod_ext : acc_r + prod_ext;

  // translation: -dot + half lsb, floor shift, clamp to 32 bits
  always_comb begin
    tneg = lavm_pkg::HALF_LSB - acc_sum;
    tsh  = tneg >>> lavm_pkg::FRAC_BITS;
    if (tsh > lavm_pkg::SAT_HI) tsat = 32'h7fff_ffff;
    else if (tsh < lavm_pkg::SAT_LO) tsat = 32'h8000_0000;
    else tsat = tsh[31:0];
  end

  always_comb begin
    row_word.row_index  = row_r;
    row_word.last_row   = (row_r == lavm_pkg::ROW_LAST);
    row_word.degenerate = bad_r;
    case (row_r)
      lavm_pkg::ROW_SIDE: begin
        row_word.col0 = 32'(s_r[0]);
        row_word.col1 = 32'(s_r[1]);
        row_word.col2 = 32'(s_r[2]);
        row_word.col3 = trans_r[0];
      end
      lavm_pkg::ROW_UP: begin
        row_word.col0 = 32'(u_r[0]);
        row_word.col1 = 32'(u_r[1]);
        row_word.col2 = 32'(u_r[2]);
        row_word.col3 = trans_r[1];
      end
      lavm_pkg::ROW_FWD: begin
        row_word.col0 = 32'(f_r[0]);
        row_word.col1 = 32'(f_r[1]);
        row_word.col2 = 32'(f_r[2]);
        row_word.col3 = trans_r[2];
      end
      default: begin
        row_word.col0 = '0;
        row_word.col1 = '0;
        row_word.col2 = '0;
        row_word.col3 = lavm_pkg::ONE_FIX;
      end
    endcase
  end

  assign last_term = ph_r && (k_r == ((state_r == lavm_pkg::B_DOT) ? 3'd2 : 3'd5));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lavm_pkg::B_IDLE:    if (q_valid) state_nxt = lavm_pkg::B_NORM_F;
      lavm_pkg::B_NORM_F:  if (stat.done) state_nxt = lavm_pkg::B_CROSS_S;
      lavm_pkg::B_CROSS_S: if (last_term) state_nxt = lavm_pkg::B_NORM_S;
      lavm_pkg::B_NORM_S:  if (stat.done) state_nxt = lavm_pkg::B_CROSS_U;
      lavm_pkg::B_CROSS_U: if (last_term) state_nxt = lavm_pkg::B_NORM_U;
      lavm_pkg::B_NORM_U:  if (stat.done) state_nxt = lavm_pkg::B_DOT;
      lavm_pkg::B_DOT: begin
        if (last_term && row_r == lavm_pkg::ROW_FWD) state_nxt = lavm_pkg::B_EMIT;
      end
      lavm_pkg::B_EMIT: begin
        if (load && row_r == lavm_pkg::ROW_LAST) state_nxt = lavm_pkg::B_IDLE;
      end
      default: state_nxt = lavm_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state_r == lavm_pkg::B_IDLE) && q_valid;
    load   = (state_r == lavm_pkg::B_EMIT) && (!out_valid_r || !out_stall);
    go_nxt = (state_nxt != state_r) &&
             (state_nxt == lavm_pkg::B_NORM_F || state_nxt == lavm_pkg::B_NORM_S ||
              state_nxt == lavm_pkg::B_NORM_U);
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lavm_pkg::B_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= row_word;
      row_r      <= row_r + 2'd1;
    end
    case (state_r)
      lavm_pkg::B_IDLE: begin
        if (q_valid) job_r <= q_job;
        k_r   <= '0;
        ph_r  <= 1'b0;
        acc_r <= '0;
        row_r <= lavm_pkg::ROW_SIDE;
      end
      lavm_pkg::B_NORM_F: begin
        if (stat.done) for (int i = 0; i < 3; i++) f_r[i] <= unit[i];
      end
      lavm_pkg::B_NORM_S: begin
        if (stat.done) begin
          for (int i = 0; i < 3; i++) s_r[i] <= unit[i];
          bad_r <= !stat.nz;
        end
      end
      lavm_pkg::B_NORM_U: begin
        if (stat.done) for (int i = 0; i < 3; i++) u_r[i] <= unit[i];
        row_r <= lavm_pkg::ROW_SIDE;
      end
      lavm_pkg::B_CROSS_S, lavm_pkg::B_CROSS_U, lavm_pkg::B_DOT: begin
        ph_r <= !ph_r;
        if (!ph_r) begin
          prod_r <= op_a * op_b;
        end else if (state_r == lavm_pkg::B_DOT) begin
          if (k_r == 3'd2) begin
            case (row_r)
              lavm_pkg::ROW_SIDE: trans_r[0] <= tsat;
              lavm_pkg::ROW_UP:   trans_r[1] <= tsat;
              default:            trans_r[2] <= tsat;
            endcase
            acc_r <= '0;
            k_r   <= '0;
            row_r <= (row_r == lavm_pkg::ROW_FWD) ? lavm_pkg::ROW_SIDE : row_r + 2'd1;
          end else begin
            acc_r <= acc_sum;
            k_r   <= k_r + 3'd1;
          end
        end else if (k_r[0]) begin
          case (k_r[2:1])
            2'd0:    raw_r[0] <= acc_sum;
            2'd1:    raw_r[1] <= acc_sum;
            default: raw_r[2] <= acc_sum;
          endcase
          acc_r <= '0;
          k_r   <= (k_r == 3'd5) ? 3'd0 : k_r + 3'd1;
        end else begin
          acc_r <= acc_sum;
          k_r   <= k_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> (state_r == lavm_pkg::B_NORM_F || state_r == lavm_pkg::B_NORM_S ||
                   state_r == lavm_pkg::B_NORM_U))
    else $error("normalize result with no sequencer waiting");
  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && row_r == lavm_pkg::ROW_LAST) |=>
      (state_r == lavm_pkg::B_IDLE && out_valid_r && out_word_r.last_row))
    else $error("last row did not close the word");
  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == lavm_pkg::B_EMIT)
    else $error("output word raised outside emit");
`endif

endmodule

/* rtl/look_at_view_matrix.sv */
// A degenerate view skips normalize work on its zero vectors. After the first row, rows
// follow one a cycle while out_stall is low.
// The shared normalize unit (one-bit-a-cycle shift, 31-step square root, FRAC_BITS+1-step
// divide) runs three times a word and limits throughput; a two-entry queue lets new
// words in meanwhile.
// Reset: synchronous active-low rst_n clears all control state; no clearing pass.
module look_at_view_matrix (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lavm_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lavm_pkg::out_word_t  out_word
);

  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  lavm_pkg::job_t push_job;
  lavm_pkg::job_t q_job;

  lavm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .push     (push),
    .q_full   (q_full),
    .push_job (push_job)
  );

  lavm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  lavm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* tb/sv/look_at_view_matrix_tb.sv */
module look_at_view_matrix_tb;

  localparam int IDLE_LIMIT = 20000;
  localparam int RAND_WORDS = 120;
  localparam logic signed [31:0] ONE = 32'sd1 <<< lavm_pkg::FRAC_BITS;
  localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  // directed rows: flag value that means the degenerate bit is not typed in
  localparam int DEG_ANY = 2;

  typedef struct {
    lavm_pkg::in_word_t word;
    int                 deg;
  } view_case_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lavm_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_stall;
  lavm_pkg::out_word_t out_word;

  lavm_pkg::out_word_t rows_due[$];
  view_case_t cases[$];
  int         n_bad;
  int         idle_cycles;
  bit         quiet;
  bit         ended;

  look_at_view_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input longint v[3], output longint o[3]);
    longint unsigned mag[3], m, sum, len, q;
    bit neg[3];
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b0;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << lavm_pkg::FRAC_BITS) + (len >> 1)) / len;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic logic signed [31:0] shift_term(input longint a[3], input longint e[3]);
    longint t, r;
    longint unsigned mg;
    t = -(a[0] * e[0] + a[1] * e[1] + a[2] * e[2]);
    t += 64'sd1 <<< (lavm_pkg::FRAC_BITS - 1);
    if (t >= 0) begin
      r = t >>> lavm_pkg::FRAC_BITS;
    end else begin
      mg = -t;
      r = -longint'((mg + (ONE - 1)) >> lavm_pkg::FRAC_BITS);
    end
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // pushes the four rows of the view matrix; returns the degenerate bit
  function automatic bit predict_view(input lavm_pkg::in_word_t w);
    longint eye[3], up[3], d[3], f[3], raw[3], s[3], u[3];
    bit deg;
    lavm_pkg::out_word_t r;
    eye = '{w.eye_x, w.eye_y, w.eye_z};
    up = '{w.upward_x, w.upward_y, w.upward_z};
    d[0] = longint'(w.eye_x) - longint'(w.aim_x);
    d[1] = longint'(w.eye_y) - longint'(w.aim_y);
    d[2] = longint'(w.eye_z) - longint'(w.aim_z);
    void'(unit_vec(d, f));
    cross3(up, f, raw);
    deg = !unit_vec(raw, s);
    cross3(f, s, raw);
    void'(unit_vec(raw, u));
    r.last_row = 1'b0;
    r.degenerate = deg;
    r.row_index = lavm_pkg::ROW_SIDE;
    r.col0 = 32'(s[0]); r.col1 = 32'(s[1]); r.col2 = 32'(s[2]);
    r.col3 = shift_term(s, eye);
    rows_due.push_back(r);
    r.row_index = lavm_pkg::ROW_UP;
    r.col0 = 32'(u[0]); r.col1 = 32'(u[1]); r.col2 = 32'(u[2]);
    r.col3 = shift_term(u, eye);
    rows_due.push_back(r);
    r.row_index = lavm_pkg::ROW_FWD;
    r.col0 = 32'(f[0]); r.col1 = 32'(f[1]); r.col2 = 32'(f[2]);
    r.col3 = shift_term(f, eye);
    rows_due.push_back(r);
    r.row_index = lavm_pkg::ROW_LAST;
    r.col0 = '0; r.col1 = '0; r.col2 = '0; r.col3 = lavm_pkg::ONE_FIX; r.last_row = 1'b1;
    rows_due.push_back(r);
    return deg;
  endfunction

  function automatic void add_case(input logic signed [31:0] ex, ey, ez, ax, ay, az,
                                   ux, uy, uz, input int deg);
    view_case_t c;
    c.word = '{ex, ey, ez, ax, ay, az, ux, uy, uz};
    c.deg = deg;
    cases.push_back(c);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
      2: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
      default: return $urandom_range(0, 1) ? MAXV : MINV;
    endcase
  endfunction

  function automatic lavm_pkg::in_word_t rand_view();
    lavm_pkg::in_word_t w;
    logic signed [31:0] k;
    w = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
          rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    case ($urandom_range(0, 9))
      0: begin
        w.aim_x = w.eye_x; w.aim_y = w.eye_y; w.aim_z = w.eye_z;
      end
      1: begin
        w.upward_x = 0; w.upward_y = 0; w.upward_z = 0;
      end
      2: begin
        // up along the view line
        k = $signed($urandom_range(0, 6)) - 3;
        w.eye_x = $signed($urandom_range(0, 32'hffff)) - 32'sh8000;
        w.eye_y = $signed($urandom_range(0, 32'hffff)) - 32'sh8000;
        w.eye_z = $signed($urandom_range(0, 32'hffff)) - 32'sh8000;
        w.aim_x = 0; w.aim_y = 0; w.aim_z = 0;
        w.upward_x = w.eye_x * k; w.upward_y = w.eye_y * k; w.upward_z = w.eye_z * k;
      end
      default: ;
    endcase
    return w;
  endfunction

  // result side: random stall bursts
  initial begin
    int left;
    left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) left--;
      else if (!quiet && $urandom_range(0, 5) == 0) left = $urandom_range(1, 8);
      out_stall <= (left > 0);
    end
  end

  // compare and watchdog sample mid-cycle, when everything driven at the edge has settled
  initial begin
    lavm_pkg::out_word_t exp_row;
    bit moved;
    n_bad = 0;
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      moved = in_valid && !in_stall;
      if (rst_n && out_valid && !out_stall) begin
        moved = 1'b1;
        if (rows_due.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected row %0d: %p", out_word.row_index, out_word);
        end else begin
          exp_row = rows_due.pop_front();
          if (out_word.row_index !== exp_row.row_index || out_word.col0 !== exp_row.col0 ||
              out_word.col1 !== exp_row.col1 || out_word.col2 !== exp_row.col2 ||
              out_word.col3 !== exp_row.col3 || out_word.last_row !== exp_row.last_row ||
              out_word.degenerate !== exp_row.degenerate) begin
            n_bad++;
            if (n_bad <= 10) $display("row differs: exp %p got %p", exp_row, out_word);
          end
        end
      end
      if (moved || !rst_n || ended) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("look_at_view_matrix: mismatch");
        $finish;
      end
    end
  end

  task automatic send_view(input lavm_pkg::in_word_t w, input int deg);
    bit took, d;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      took = !in_stall;
      if (took) begin
        d = predict_view(w);
        if (deg != DEG_ANY && d != deg[0]) begin
          n_bad++;
          if (n_bad <= 10) $display("degenerate flag: typed %0d predicted %0d", deg, d);
        end
      end
      @(posedge clk);
    end while (!took);
  endtask

  initial begin
    lavm_pkg::in_word_t w;
    quiet = 1'b0;
    ended = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_case(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0, 0);
    add_case(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, ONE, 0, 1);
    add_case(0, 0, ONE, 0, 0, 0, 0, 0, 0, 1);
    add_case(0, ONE, 0, 0, 0, 0, 0, 3 * ONE, 0, 1);
    add_case(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_case(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, ONE, 0, DEG_ANY);
    add_case(MINV, MINV, MINV, MAXV, MAXV, MAXV, ONE, 0, 0, DEG_ANY);
    add_case(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MAXV, MAXV, DEG_ANY);
    add_case(MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV, MINV, MINV, DEG_ANY);
    add_case(MAXV, MAXV, MAXV, 0, 0, 0, ONE, 0, 0, 0);
    add_case(MINV, MINV, MINV, 0, 0, 0, 0, 0, ONE, 0);
    add_case(3 * ONE, -2 * ONE, ONE, -ONE, 4 * ONE, 0, 0, 0, -ONE, DEG_ANY);
    add_case(1, 0, 0, 0, 0, 0, 0, 1, 0, 0);
    add_case(-1, -1, -1, 0, 0, 0, 0, MAXV, 0, DEG_ANY);
    add_case(0, 0, 10 * ONE, 0, 0, 0, 0, 0, MINV, 1);
    add_case(-32'sd1, 32'sd0, MAXV, MINV, 32'sd1, 32'sd0, 32'sd1, MINV, -32'sd1, DEG_ANY);
    foreach (cases[i]) send_view(cases[i].word, cases[i].deg);

    // let the block drain before the random part
    in_valid <= 1'b0;
    wait (rows_due.size() == 0);
    @(posedge clk);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS - 20) quiet = 1'b1;
      w = rand_view();
      send_view(w, DEG_ANY);
    end
    in_valid <= 1'b0;
    wait (rows_due.size() == 0);
    ended = 1'b1;
    repeat (400) @(posedge clk);
    if (n_bad == 0 && rows_due.size() == 0) begin
      $display("look_at_view_matrix: match");
    end else begin
      $display("look_at_view_matrix: mismatch");
    end
    $finish;
  end

endmodule
